[rtl/bal_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bal_pkg;

    localparam int DEPTH     = 64;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int WORD_W    = 32;
    localparam int POS_W     = 16;
    localparam int CNT_W     = 7;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [WORD_W-1:0] value;
        logic signed [POS_W-1:0]  position;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [POS_W-1:0] found_position;
        logic [CNT_W-1:0]        count;
        logic                    is_empty;
        logic                    is_full;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_UP,
        ST_UP_LAST,
        ST_PUT,
        ST_SHIFT_DOWN,
        ST_DOWN_LAST,
        ST_SEARCH,
        ST_SEARCH_LAST
    } state_t;

endpackage

`default_nettype wire

[rtl/bal_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/bounded_array_list.sv]
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to 64 signed words kept in one single-port-per-side RAM.
// A command is taken when start is high and busy is low; its one result shows
// on result for exactly one cycle with done high, and the receiver cannot hold
// it off. Append, pop, refused commands, unknown kinds, an insert at the end,
// a remove of the last entry and a search of an empty list finish from idle
// (done on the next cycle). An insert at slot s shifts entries last to s up one
// slot, then writes the new word at s; a remove at slot s shifts entries s + 1
// to last down one slot; a search reads from slot 0 until a match or the last
// entry. The walk moves one entry per cycle through the RAM's read and write
// ports. No clearing pass is needed after reset.
module bounded_array_list (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire bal_pkg::cmd_t                 cmd,
    output logic                               done,
    output bal_pkg::result_t                   result,
    input  wire logic                          cfg_we,
    input  wire logic [bal_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bal_pkg::CFG_W-1:0]     cfg_data
);

    localparam int ADDR_W = bal_pkg::ADDR_W;
    localparam int CNT_W  = bal_pkg::CNT_W;
    localparam int POS_W  = bal_pkg::POS_W;
    localparam logic [CNT_W-1:0]  CNT_ONE  = 1;
    localparam logic [ADDR_W-1:0] ADDR_ONE = 1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(bal_pkg::DEPTH);

    bal_pkg::state_t state_reg, state_next;

    logic [POS_W-1:0]              base_reg;
    logic [CNT_W-1:0]              capacity_reg;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [ADDR_W-1:0]             ptr_reg, ptr_next;
    logic [ADDR_W-1:0]             wa_reg, wa_next;
    logic                          pend_reg, pend_next;
    logic [ADDR_W-1:0]             slot_reg, slot_next;
    logic [bal_pkg::WORD_W-1:0]    value_reg, value_next;
    logic [bal_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [POS_W-1:0]              found_reg, found_next;
    logic                          done_reg, done_next;

    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [bal_pkg::WORD_W-1:0]    ram_wdata;
    logic [bal_pkg::WORD_W-1:0]    ram_rdata;

    logic [POS_W:0]                slot_full;
    logic                          slot_neg;
    logic [ADDR_W-1:0]             slot_addr;
    logic [ADDR_W-1:0]             last_addr;
    logic [CNT_W-1:0]              cap_eff;
    logic                          list_full;
    logic                          list_empty;
    logic                          ins_ok;
    logic                          ins_at_end;
    logic                          rem_ok;
    logic                          rem_at_last;
    logic                          match;

    bal_ram #(
        .WIDTH (bal_pkg::WORD_W),
        .DEPTH (bal_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // Slot offset without wrap: sign-extend both to one extra bit.
    assign slot_full   = {cmd.position[POS_W-1], cmd.position} - {base_reg[POS_W-1], base_reg};
    assign slot_neg    = slot_full[POS_W];
    assign slot_addr   = slot_full[ADDR_W-1:0];
    assign last_addr   = count_reg[ADDR_W-1:0] - ADDR_ONE;
    assign cap_eff     = (capacity_reg > CNT_MAX) ? CNT_MAX : capacity_reg;
    assign list_full   = count_reg >= cap_eff;
    assign list_empty  = count_reg == '0;
    assign ins_ok      = !slot_neg && !(slot_full[POS_W-1:0] > POS_W'(count_reg));
    assign ins_at_end  = slot_full[POS_W-1:0] == POS_W'(count_reg);
    assign rem_ok      = !slot_neg && (slot_full[POS_W-1:0] < POS_W'(count_reg));
    assign rem_at_last = slot_addr == last_addr;
    assign match       = pend_reg && (ram_rdata == value_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bal_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.kind)
                        bal_pkg::KIND_INSERT:
                        begin
                            if (!list_full && ins_ok && !ins_at_end)
                            begin
                                state_next = bal_pkg::ST_SHIFT_UP;
                            end
                        end
                        bal_pkg::KIND_REMOVE:
                        begin
                            if (!list_empty && rem_ok && !rem_at_last)
                            begin
                                state_next = bal_pkg::ST_SHIFT_DOWN;
                            end
                        end
                        bal_pkg::KIND_SEARCH:
                        begin
                            if (!list_empty)
                            begin
                                state_next = bal_pkg::ST_SEARCH;
                            end
                        end
                        default:
                        begin
                            state_next = bal_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            bal_pkg::ST_SHIFT_UP:
            begin
                if (ptr_reg == slot_reg)
                begin
                    state_next = bal_pkg::ST_UP_LAST;
                end
            end
            bal_pkg::ST_UP_LAST:
            begin
                state_next = bal_pkg::ST_PUT;
            end
            bal_pkg::ST_PUT:
            begin
                state_next = bal_pkg::ST_IDLE;
            end
            bal_pkg::ST_SHIFT_DOWN:
            begin
                if (ptr_reg == last_addr)
                begin
                    state_next = bal_pkg::ST_DOWN_LAST;
                end
            end
            bal_pkg::ST_DOWN_LAST:
            begin
                state_next = bal_pkg::ST_IDLE;
            end
            bal_pkg::ST_SEARCH:
            begin
                if (match)
                begin
                    state_next = bal_pkg::ST_IDLE;
                end
                else if (ptr_reg == last_addr)
                begin
                    state_next = bal_pkg::ST_SEARCH_LAST;
                end
            end
            bal_pkg::ST_SEARCH_LAST:
            begin
                state_next = bal_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bal_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        wa_next     = wa_reg;
        pend_next   = 1'b0;
        slot_next   = slot_reg;
        value_next  = value_reg;
        status_next = status_reg;
        found_next  = found_reg;
        done_next   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = wa_reg;
        ram_wdata   = ram_rdata;

        unique case (state_reg)
            bal_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    value_next  = cmd.value;
                    slot_next   = slot_addr;
                    found_next  = '0;
                    status_next = bal_pkg::STATUS_DONE;
                    unique case (cmd.kind)
                        bal_pkg::KIND_APPEND:
                        begin
                            done_next = 1'b1;
                            if (list_full)
                            begin
                                status_next = bal_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[ADDR_W-1:0];
                                ram_wdata  = cmd.value;
                                count_next = count_reg + CNT_ONE;
                            end
                        end
                        bal_pkg::KIND_INSERT:
                        begin
                            if (list_full)
                            begin
                                status_next = bal_pkg::STATUS_FULL;
                                done_next   = 1'b1;
                            end
                            else if (!ins_ok)
                            begin
                                status_next = bal_pkg::STATUS_RANGE;
                                done_next   = 1'b1;
                            end
                            else if (ins_at_end)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = slot_addr;
                                ram_wdata  = cmd.value;
                                count_next = count_reg + CNT_ONE;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                // walk down from the last entry
                                ptr_next = last_addr;
                            end
                        end
                        bal_pkg::KIND_POP:
                        begin
                            done_next = 1'b1;
                            if (list_empty)
                            begin
                                status_next = bal_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_ONE;
                            end
                        end
                        bal_pkg::KIND_REMOVE:
                        begin
                            if (list_empty)
                            begin
                                status_next = bal_pkg::STATUS_EMPTY;
                                done_next   = 1'b1;
                            end
                            else if (!rem_ok)
                            begin
                                status_next = bal_pkg::STATUS_RANGE;
                                done_next   = 1'b1;
                            end
                            else if (rem_at_last)
                            begin
                                count_next = count_reg - CNT_ONE;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                ptr_next = slot_addr + ADDR_ONE;
                            end
                        end
                        bal_pkg::KIND_SEARCH:
                        begin
                            if (list_empty)
                            begin
                                status_next = bal_pkg::STATUS_NOT_FOUND;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                ptr_next = '0;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            bal_pkg::ST_SHIFT_UP:
            begin
                // read entry p now, write it to p + 1 next cycle
                ram_we    = pend_reg;
                pend_next = 1'b1;
                wa_next   = ptr_reg + ADDR_ONE;
                ptr_next  = ptr_reg - ADDR_ONE;
            end
            bal_pkg::ST_UP_LAST:
            begin
                ram_we = 1'b1;
            end
            bal_pkg::ST_PUT:
            begin
                ram_we      = 1'b1;
                ram_waddr   = slot_reg;
                ram_wdata   = value_reg;
                count_next  = count_reg + CNT_ONE;
                status_next = bal_pkg::STATUS_DONE;
                done_next   = 1'b1;
            end
            bal_pkg::ST_SHIFT_DOWN:
            begin
                ram_we    = pend_reg;
                pend_next = 1'b1;
                wa_next   = ptr_reg - ADDR_ONE;
                ptr_next  = ptr_reg + ADDR_ONE;
            end
            bal_pkg::ST_DOWN_LAST:
            begin
                ram_we     = 1'b1;
                count_next = count_reg - CNT_ONE;
                done_next  = 1'b1;
            end
            bal_pkg::ST_SEARCH:
            begin
                // wa tracks the slot whose data arrives this cycle
                pend_next = 1'b1;
                wa_next   = ptr_reg;
                ptr_next  = ptr_reg + ADDR_ONE;
                if (match)
                begin
                    found_next  = base_reg + POS_W'(wa_reg);
                    status_next = bal_pkg::STATUS_DONE;
                    done_next   = 1'b1;
                end
            end
            bal_pkg::ST_SEARCH_LAST:
            begin
                done_next = 1'b1;
                if (ram_rdata == value_reg)
                begin
                    found_next  = base_reg + POS_W'(wa_reg);
                    status_next = bal_pkg::STATUS_DONE;
                end
                else
                begin
                    status_next = bal_pkg::STATUS_NOT_FOUND;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bal_pkg::ST_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= bal_pkg::STATUS_DONE;
            found_reg    <= '0;
            base_reg     <= '0;
            capacity_reg <= CNT_MAX;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            found_reg  <= found_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    bal_pkg::REG_INDEX_BASE:
                    begin
                        base_reg <= cfg_data[POS_W-1:0];
                    end
                    bal_pkg::REG_CAPACITY:
                    begin
                        capacity_reg <= cfg_data[CNT_W-1:0];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        wa_reg    <= wa_next;
        slot_reg  <= slot_next;
        value_reg <= value_next;
    end

    assign busy                  = state_reg != bal_pkg::ST_IDLE;
    assign done                  = done_reg;
    assign result.status         = status_reg;
    assign result.found_position = found_reg;
    assign result.count          = count_reg;
    assign result.is_empty       = list_empty;
    assign result.is_full        = list_full;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("entry count beyond storage depth");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result strobe while a walk is running");

    a_count_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> done_reg)
        else $error("entry count moved without a result");

    a_found_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != bal_pkg::STATUS_DONE) |-> found_reg == '0)
        else $error("found position set on a failed command");

endmodule

`default_nettype wire
